// ----- hw/rtl/cv3_pkg.sv -----
// Shared constants, command codes and handshake structs for the 3x3 convolution core.
// No dependencies; every other file of the core imports this package.
`default_nettype none

package cv3_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int IMG_SIZE_DEF   = 13;
    localparam int IN_CH_DEF      = 8;
    localparam int OUT_CH_DEF     = 16;
    localparam int DATA_WIDTH_DEF = 16;

    // Fixed formats of the stream fields.
    localparam int PIX_FIELDS = 8;
    localparam int FRAC_BITS  = 8;
    localparam int ACC_W      = 40;
    localparam int KSIZE      = 9;
    localparam int IDX_W      = 11;
    localparam int POS_W      = 4;
    localparam int CMD_W      = 2;

    // Command codes carried on s_axis_tuser.
    localparam logic [CMD_W-1:0] CMD_WEIGHT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BIAS   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PIXEL  = 2'd2;

    // Kinds of queue entries.
    localparam logic ENT_LOAD    = 1'b0;
    localparam logic ENT_COMPUTE = 1'b1;
    localparam logic SEL_WEIGHT  = 1'b0;
    localparam logic SEL_BIAS    = 1'b1;

    // Status of the queue between front and back.
    typedef struct packed {
        logic valid;
        logic full;
    } q_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cv3_queue.sv -----
// Two-entry queue that decouples the front end from the MAC back end.
// Depends on cv3_pkg for the status struct.
`default_nettype none

module cv3_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output cv3_pkg::q_stat_t      stat,
    output logic      [WIDTH-1:0] head
);
    import cv3_pkg::*;

    logic [WIDTH-1:0] slot_reg [2];
    logic             rd_ptr_reg, rd_ptr_next;
    logic             wr_ptr_reg, wr_ptr_next;
    logic [1:0]       count_reg, count_next;

    // Pointer and fill-count update.
    always_comb begin
        rd_ptr_next = rd_ptr_reg ^ pop;
        wr_ptr_next = wr_ptr_reg ^ push;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots carry no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head       = slot_reg[rd_ptr_reg];
    assign stat.valid = (count_reg != 2'd0);
    assign stat.full  = (count_reg == 2'd2);

endmodule

`default_nettype wire

// ----- hw/rtl/cv3_front.sv -----
// Front end: accepts beats, classifies them, keeps the line buffers and 3x3 windows.
// Depends on cv3_pkg; feeds cv3_queue.
`default_nettype none

module cv3_front #(
    parameter int IMG_SIZE   = cv3_pkg::IMG_SIZE_DEF,
    parameter int IN_CH      = cv3_pkg::IN_CH_DEF,
    parameter int OUT_CH     = cv3_pkg::OUT_CH_DEF,
    parameter int DATA_WIDTH = cv3_pkg::DATA_WIDTH_DEF,
    parameter int TD_W       = 160,
    parameter int ENT_W      = 8
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [TD_W-1:0]           s_axis_tdata,
    input  wire logic [cv3_pkg::CMD_W-1:0] s_axis_tuser,
    input  wire cv3_pkg::q_stat_t          q_stat,
    output logic                           q_push,
    output logic [ENT_W-1:0]               q_data
);
    import cv3_pkg::*;

    localparam int DW      = DATA_WIDTH;
    localparam int CNT_W   = $clog2(IMG_SIZE);
    localparam int NWIN    = IN_CH * KSIZE;
    localparam int WDEPTH  = OUT_CH * IN_CH * KSIZE;
    localparam int VAL_LSB = 2 + IDX_W;
    localparam int ROW_LSB = VAL_LSB + DW;
    localparam int COL_LSB = ROW_LSB + POS_W;
    localparam int WIN_LSB = COL_LSB + POS_W;

    logic [IDX_W-1:0]    idx;
    logic [DW-1:0]       val;
    logic                beat;
    logic [DW-1:0]       px [IN_CH];
    logic [DW-1:0]       old_rd [IN_CH];
    logic [DW-1:0]       new_rd [IN_CH];
    logic [DW-1:0]       win_reg [NWIN];
    logic [DW-1:0]       win_next [NWIN];
    logic [IN_CH*DW-1:0] line_old_reg [IMG_SIZE];
    logic [IN_CH*DW-1:0] line_new_reg [IMG_SIZE];
    logic [IMG_SIZE-1:0] line_vld_reg;
    logic [CNT_W-1:0]    row_reg, row_next;
    logic [CNT_W-1:0]    col_reg, col_next;
    logic                is_pixel;
    logic                has_out;

    assign idx           = s_axis_tdata[IDX_W-1:0];
    assign val           = s_axis_tdata[IDX_W +: DW];
    assign s_axis_tready = !q_stat.full;
    assign beat          = s_axis_tvalid && s_axis_tready;
    assign is_pixel      = (s_axis_tuser == CMD_PIXEL);
    assign has_out       = (row_reg >= CNT_W'(2)) && (col_reg >= CNT_W'(2));

    // Channel samples; channels past the carried fields read as zero.
    for (genvar g = 0; g < IN_CH; g++) begin : g_px
        if (g < PIX_FIELDS) begin : g_live
            assign px[g] = s_axis_tdata[IDX_W + DW*(1+g) +: DW];
        end else begin : g_zero
            assign px[g] = '0;
        end
        assign old_rd[g] = line_vld_reg[col_reg] ?
                           line_old_reg[col_reg][g*DW +: DW] : '0;
        assign new_rd[g] = line_vld_reg[col_reg] ?
                           line_new_reg[col_reg][g*DW +: DW] : '0;
    end

    // Window shift: each row moves left, the new column enters on the right.
    always_comb begin
        for (int ic = 0; ic < IN_CH; ic++) begin
            for (int kr = 0; kr < 3; kr++) begin
                win_next[ic*KSIZE + kr*3]     = win_reg[ic*KSIZE + kr*3 + 1];
                win_next[ic*KSIZE + kr*3 + 1] = win_reg[ic*KSIZE + kr*3 + 2];
            end
            win_next[ic*KSIZE + 2] = old_rd[ic];
            win_next[ic*KSIZE + 5] = new_rd[ic];
            win_next[ic*KSIZE + 8] = px[ic];
        end
    end

    // Raster counters, wrapping at the end of a row and of a frame.
    always_comb begin
        row_next = row_reg;
        col_next = col_reg + CNT_W'(1);
        if (32'(col_reg) == IMG_SIZE - 1) begin
            col_next = '0;
            row_next = (32'(row_reg) == IMG_SIZE - 1) ? '0 : row_reg + CNT_W'(1);
        end
    end

    // Queue entry build: loads in range, and pixels that complete a window.
    always_comb begin
        q_push = 1'b0;
        q_data = '0;
        q_data[2 +: IDX_W]   = idx;
        q_data[VAL_LSB +: DW] = val;
        q_data[ROW_LSB +: POS_W] = POS_W'(row_reg - CNT_W'(2));
        q_data[COL_LSB +: POS_W] = POS_W'(col_reg - CNT_W'(2));
        for (int k = 0; k < NWIN; k++) begin
            q_data[WIN_LSB + k*DW +: DW] = win_next[k];
        end
        case (s_axis_tuser)
            CMD_WEIGHT: begin
                q_data[0] = ENT_LOAD;
                q_data[1] = SEL_WEIGHT;
                q_push    = beat && (32'(idx) < WDEPTH);
            end
            CMD_BIAS: begin
                q_data[0] = ENT_LOAD;
                q_data[1] = SEL_BIAS;
                q_push    = beat && (32'(idx) < OUT_CH);
            end
            CMD_PIXEL: begin
                q_data[0] = ENT_COMPUTE;
                q_push    = beat && has_out;
            end
            default: begin
                q_push = 1'b0;
            end
        endcase
    end

    // Control state: counters, line valid bits and window registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg      <= '0;
            col_reg      <= '0;
            line_vld_reg <= '0;
            for (int k = 0; k < NWIN; k++) begin
                win_reg[k] <= '0;
            end
        end else if (beat && is_pixel) begin
            row_reg               <= row_next;
            col_reg               <= col_next;
            line_vld_reg[col_reg] <= 1'b1;
            for (int k = 0; k < NWIN; k++) begin
                win_reg[k] <= win_next[k];
            end
        end
    end

    // Line buffer rows: the newer row ages into the older one.
    always_ff @(posedge aclk) begin
        if (beat && is_pixel) begin
            for (int ic = 0; ic < IN_CH; ic++) begin
                line_old_reg[col_reg][ic*DW +: DW] <= new_rd[ic];
                line_new_reg[col_reg][ic*DW +: DW] <= px[ic];
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/cv3_back.sv -----
// Back end: applies loads to the weight and bias stores and runs one MAC per output.
// Depends on cv3_pkg; drains cv3_queue and drives the result stream.
`default_nettype none

module cv3_back #(
    parameter int IN_CH      = cv3_pkg::IN_CH_DEF,
    parameter int OUT_CH     = cv3_pkg::OUT_CH_DEF,
    parameter int DATA_WIDTH = cv3_pkg::DATA_WIDTH_DEF,
    parameter int MD_W       = 32,
    parameter int ENT_W      = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cv3_pkg::q_stat_t q_stat,
    input  wire logic [ENT_W-1:0] q_head,
    output logic                  q_pop,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [MD_W-1:0]       m_axis_tdata,
    output logic                  m_axis_tlast
);
    import cv3_pkg::*;

    localparam int DW      = DATA_WIDTH;
    localparam int KN      = IN_CH * KSIZE;
    localparam int WDEPTH  = OUT_CH * KN;
    localparam int WA_W    = $clog2(WDEPTH);
    localparam int K_W     = $clog2(KN + 1);
    localparam int KS_W    = (KN > 1) ? $clog2(KN) : 1;
    localparam int OC_W    = (OUT_CH > 1) ? $clog2(OUT_CH) : 1;
    localparam int VAL_LSB = 2 + IDX_W;
    localparam int ROW_LSB = VAL_LSB + DW;
    localparam int COL_LSB = ROW_LSB + POS_W;
    localparam int WIN_LSB = COL_LSB + POS_W;
    localparam int SH_W    = ACC_W - FRAC_BITS;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MAC  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [DW-1:0]         wmem [WDEPTH];
    logic [DW-1:0]         w_rd_reg;
    logic [DW-1:0]         bias_reg [OUT_CH];
    logic [OC_W-1:0]       oc_reg;
    logic [WA_W-1:0]       base_reg;
    logic [K_W-1:0]        k_reg;
    logic [KS_W-1:0]       k_d_reg;
    logic                  v1_reg, v2_reg;
    logic signed [2*DW-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [DW-1:0]         win_sel;
    logic                  issue;
    logic                  out_free;
    logic                  last_oc;
    logic [SH_W-1:0]       shifted;
    logic [DW-2:0]         relu_val;
    logic                  out_vld_reg;
    logic [MD_W-1:0]       out_data_reg;
    logic                  out_last_reg;
    logic                  is_load;
    logic [OC_W-1:0]       oc_first;

    assign is_load  = (q_head[0] == ENT_LOAD);
    assign issue    = (state_reg == ST_MAC) && (32'(k_reg) < KN);
    assign win_sel  = q_head[WIN_LSB + 32'(k_d_reg)*DW +: DW];
    assign out_free = !out_vld_reg || m_axis_tready;
    assign last_oc  = (32'(oc_reg) == OUT_CH - 1);
    assign oc_first = '0;

    // ReLU, truncation to unsigned Q7.8 and saturation at the top.
    always_comb begin
        shifted = SH_W'(acc_reg >>> FRAC_BITS);
        if (acc_reg[ACC_W-1]) begin
            relu_val = '0;
        end else if (|shifted[SH_W-1:DW-1]) begin
            relu_val = '1;
        end else begin
            relu_val = shifted[DW-2:0];
        end
    end

    // Sequencer over loads and output channels.
    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (q_stat.valid) begin
                    if (is_load) begin
                        q_pop = 1'b1;
                    end else begin
                        state_next = ST_MAC;
                    end
                end
            end
            ST_MAC: begin
                if (!issue && !v1_reg && !v2_reg) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    if (last_oc) begin
                        q_pop      = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_MAC;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            if (state_reg == ST_FIN && out_free) begin
                out_vld_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Weight store: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && q_stat.valid && is_load && q_head[1] == SEL_WEIGHT) begin
            wmem[q_head[2 +: WA_W]] <= q_head[VAL_LSB +: DW];
        end
        w_rd_reg <= wmem[WA_W'(32'(base_reg) + 32'(k_reg))];
    end

    // Bias words.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && q_stat.valid && is_load && q_head[1] == SEL_BIAS) begin
            bias_reg[q_head[2 +: OC_W]] <= q_head[VAL_LSB +: DW];
        end
    end

    // MAC datapath: address, read, multiply, accumulate.
    always_ff @(posedge aclk) begin
        k_d_reg  <= KS_W'(k_reg);
        prod_reg <= $signed(w_rd_reg) * $signed(win_sel);
        if (state_reg == ST_IDLE) begin
            oc_reg   <= oc_first;
            base_reg <= '0;
            k_reg    <= '0;
            acc_reg  <= ACC_W'($signed(bias_reg[oc_first])) <<< FRAC_BITS;
        end else if (state_reg == ST_FIN) begin
            if (out_free && !last_oc) begin
                oc_reg   <= oc_reg + OC_W'(1);
                base_reg <= base_reg + WA_W'(KN);
                k_reg    <= '0;
                acc_reg  <= ACC_W'($signed(bias_reg[oc_reg + OC_W'(1)])) <<< FRAC_BITS;
            end
        end else begin
            if (issue) begin
                k_reg <= k_reg + K_W'(1);
            end
            if (v2_reg) begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    // Result register: holds a beat while the next channel is computed.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_FIN && out_free) begin
            out_data_reg <= MD_W'({relu_val, POS_W'(oc_reg),
                                   q_head[COL_LSB +: POS_W], q_head[ROW_LSB +: POS_W]});
            out_last_reg <= last_oc;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/conv3x3_relu_line_buffer_core.sv -----
// Top level of the 3x3 valid convolution with bias and ReLU.
// Depends on cv3_pkg, cv3_front, cv3_queue and cv3_back.
`default_nettype none

// Load beats (tuser 0 weight, 1 bias) are applied once they reach the back end. A
// pixel beat is taken by the front end, which shifts the line buffers and windows;
// pixels from row 2 and column 2 on then yield OUT_CH results, each computed by a
// single multiply-accumulate unit that steps through the IN_CH*9 weights of one
// output channel. This single MAC and the one read port of the weight store set
// the pace of a producing pixel. A two-entry queue lets the front accept further
// beats while the back end works.
module conv3x3_relu_line_buffer_core #(
    parameter int IMG_SIZE   = cv3_pkg::IMG_SIZE_DEF,
    parameter int IN_CH      = cv3_pkg::IN_CH_DEF,
    parameter int OUT_CH     = cv3_pkg::OUT_CH_DEF,
    parameter int DATA_WIDTH = cv3_pkg::DATA_WIDTH_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // load_index, load_value, pix_ch0 .. pix_ch7, zero padded
    input  wire logic [((cv3_pkg::IDX_W + DATA_WIDTH*(1+cv3_pkg::PIX_FIELDS))+7)/8*8-1:0]
                      s_axis_tdata,
    // cmd
    input  wire logic [cv3_pkg::CMD_W-1:0] s_axis_tuser,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // out_row, out_col, out_channel, out_value, zero padded
    output logic [((3*cv3_pkg::POS_W + DATA_WIDTH - 1)+7)/8*8-1:0] m_axis_tdata,
    output logic      m_axis_tlast
);
    import cv3_pkg::*;

    localparam int TD_W  = ((IDX_W + DATA_WIDTH*(1+PIX_FIELDS))+7)/8*8;
    localparam int MD_W  = ((3*POS_W + DATA_WIDTH - 1)+7)/8*8;
    localparam int ENT_W = 2 + IDX_W + DATA_WIDTH + 2*POS_W + IN_CH*KSIZE*DATA_WIDTH;

    q_stat_t          q_stat;
    logic             q_push;
    logic             q_pop;
    logic [ENT_W-1:0] q_data;
    logic [ENT_W-1:0] q_head;

    cv3_front #(
        .IMG_SIZE(IMG_SIZE), .IN_CH(IN_CH), .OUT_CH(OUT_CH),
        .DATA_WIDTH(DATA_WIDTH), .TD_W(TD_W), .ENT_W(ENT_W)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .q_stat(q_stat), .q_push(q_push), .q_data(q_data)
    );

    cv3_queue #(
        .WIDTH(ENT_W)
    ) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .push_data(q_data), .pop(q_pop),
        .stat(q_stat), .head(q_head)
    );

    cv3_back #(
        .IN_CH(IN_CH), .OUT_CH(OUT_CH), .DATA_WIDTH(DATA_WIDTH),
        .MD_W(MD_W), .ENT_W(ENT_W)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_stat(q_stat), .q_head(q_head), .q_pop(q_pop),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    // The queue is never written while full.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_stat.full)
        else $error("queue written while full");

    // The queue is never drained while empty.
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_stat.valid)
        else $error("queue popped while empty");

    // The last beat of a run carries the final output channel.
    a_last_channel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tlast) |->
            (m_axis_tdata[2*POS_W +: POS_W] == POS_W'(OUT_CH - 1)))
        else $error("tlast on wrong channel");

    // No result is offered right after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

`default_nettype wire
